// File: src/scalar_to_rgb_colormap_top_macros.svh
// -----------------------------------------------------------------------------
// Colormap assertion macros
// Shared concurrent assertion forms for the colormap checker.
// -----------------------------------------------------------------------------
`ifndef SCALAR_TO_RGB_COLORMAP_TOP_MACROS_SVH
`define SCALAR_TO_RGB_COLORMAP_TOP_MACROS_SVH

// property that must hold at every edge out of reset
`define CMAP_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// condition now implies property at the next edge
`define CMAP_ASSERT_NEXT(lbl, clk, rst_n, cond, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
		else $error(msg);

`endif

// File: src/cmap_pkg.sv
// -----------------------------------------------------------------------------
// Colormap package
// Types, constants, color tables and helper functions for the colormap pipe.
// -----------------------------------------------------------------------------
package cmap_pkg;

	localparam int SAMPLE_BITS    = 16;
	localparam int NORM_FRAC_BITS = 16;
	localparam int TW             = NORM_FRAC_BITS + 1;   // t in [0, ONE]
	localparam int NW             = NORM_FRAC_BITS + 12;  // signed channel numerator
	localparam int AW             = 10;                   // table entry, thousandths
	localparam int YW             = 15;                   // scaled value, up to 255*125
	localparam int RW             = 24;
	localparam int RSH            = 23;
	localparam int ADDR_W         = 4;
	localparam int DIV10_SH       = NORM_FRAC_BITS + 8;
	localparam int DIV10_W        = NORM_FRAC_BITS + 5;

	localparam logic [TW-1:0] T_ONE = TW'(1) << NORM_FRAC_BITS;
	localparam logic [DIV10_W-1:0] DIV10_MUL =
		DIV10_W'(((64'd1 << DIV10_SH) + 64'd9) / 64'd10);

	typedef enum logic [4:0] {
		MAP_JET      = 5'd0,
		MAP_TURBO    = 5'd1,
		MAP_VIRIDIS  = 5'd2,
		MAP_INFERNO  = 5'd3,
		MAP_HOT      = 5'd4,
		MAP_COOL     = 5'd5,
		MAP_GRAY     = 5'd6,
		MAP_GRAY_INV = 5'd7,
		MAP_SPRING   = 5'd8,
		MAP_SUMMER   = 5'd9,
		MAP_AUTUMN   = 5'd10,
		MAP_WINTER   = 5'd11,
		MAP_COPPER   = 5'd12,
		MAP_PINK     = 5'd13,
		MAP_OCEAN    = 5'd14,
		MAP_TERRAIN  = 5'd15,
		MAP_RAINBOW  = 5'd16,
		MAP_HSV      = 5'd17,
		MAP_HSV_ALT  = 5'd18
	} cmap_t;

	typedef enum logic [1:0] {
		REG_MAP_SEL   = 2'd0,
		REG_RANGE_MIN = 2'd1,
		REG_SPAN_GAIN = 2'd2
	} reg_t;

	// channel denominator = k * 2^s * ONE
	typedef enum logic [2:0] {
		DEN_1, DEN_2, DEN_4, DEN_32, DEN_5, DEN_10, DEN_400, DEN_1000
	} den_t;

	typedef logic signed [NW-1:0] num_t;

	localparam num_t N_ONE = num_t'(64'd1 << NORM_FRAC_BITS);

	typedef struct packed {
		num_t num;
		den_t den;
	} chan_t;

	typedef struct packed {
		logic          valid;
		logic [TW-1:0] t;
	} t_beat_t;

	typedef struct packed {
		logic            valid;
		chan_t [2:0]     ch;
	} shade_beat_t;

	localparam logic [AW-1:0] TURBO [3][8] = '{
		'{10'd190, 10'd70,  10'd0,    10'd490,  10'd1000, 10'd1000, 10'd840, 10'd500},
		'{10'd0,   10'd150, 10'd650,  10'd950,  10'd1000, 10'd440,  10'd0,   10'd0},
		'{10'd500, 10'd840, 10'd1000, 10'd1000, 10'd950,  10'd650,  10'd150, 10'd0}};
	localparam logic [AW-1:0] VIRIDIS [3][6] = '{
		'{10'd267, 10'd282, 10'd253, 10'd163, 10'd128, 10'd267},
		'{10'd4,   10'd141, 10'd365, 10'd659, 10'd808, 10'd992},
		'{10'd329, 10'd458, 10'd659, 10'd788, 10'd878, 10'd984}};
	localparam logic [AW-1:0] INFERNO [3][6] = '{
		'{10'd1,  10'd302, 10'd601, 10'd903, 10'd1000, 10'd988},
		'{10'd0,  10'd137, 10'd287, 10'd428, 10'd729,  10'd998},
		'{10'd13, 10'd295, 10'd573, 10'd758, 10'd964,  10'd998}};

	function automatic logic [AW-1:0] lut_entry(cmap_t m, logic [1:0] c, logic [2:0] i);
		logic [AW-1:0] e;
		e = '0;
		if (c != 2'd3) begin
			case (m)
				MAP_TURBO:   e = TURBO[c][i];
				MAP_VIRIDIS: if (i < 3'd6) e = VIRIDIS[c][i];
				MAP_INFERNO: if (i < 3'd6) e = INFERNO[c][i];
				default:     e = '0;
			endcase
		end
		return e;
	endfunction

	function automatic chan_t mk(num_t n, den_t d);
		chan_t r;
		r.num = n;
		r.den = d;
		return r;
	endfunction

	function automatic logic [2:0] den_shift(den_t d);
		logic [2:0] s;
		case (d)
			DEN_2, DEN_10: s = 3'd1;
			DEN_4:         s = 3'd2;
			DEN_32:        s = 3'd5;
			DEN_400:       s = 3'd4;
			DEN_1000:      s = 3'd3;
			default:       s = 3'd0;
		endcase
		return s;
	endfunction

	// odd factor: 0 -> 1, 1 -> 5, 2 -> 25, 3 -> 125
	function automatic logic [1:0] den_kc(den_t d);
		logic [1:0] k;
		case (d)
			DEN_5, DEN_10: k = 2'd1;
			DEN_400:       k = 2'd2;
			DEN_1000:      k = 2'd3;
			default:       k = 2'd0;
		endcase
		return k;
	endfunction

	function automatic num_t den_full(den_t d);
		num_t v;
		case (d)
			DEN_2:    v = N_ONE <<< 1;
			DEN_4:    v = N_ONE <<< 2;
			DEN_32:   v = N_ONE <<< 5;
			DEN_5:    v = N_ONE * num_t'(5);
			DEN_10:   v = N_ONE * num_t'(10);
			DEN_400:  v = N_ONE * num_t'(400);
			DEN_1000: v = N_ONE * num_t'(1000);
			default:  v = N_ONE;
		endcase
		return v;
	endfunction

	// ceil(2^RSH / k); exact floor(y/k) for y below 2^YW
	function automatic logic [RW-1:0] k_recip(logic [1:0] kc);
		logic [RW-1:0] r;
		case (kc)
			2'd1:    r = 24'd1677722;
			2'd2:    r = 24'd335545;
			2'd3:    r = 24'd67109;
			default: r = 24'd8388608;
		endcase
		return r;
	endfunction

endpackage

// File: src/cmap_norm.sv
// -----------------------------------------------------------------------------
// Colormap normalizer
// Offset, gain multiply and saturation of the sample to t in Q1.F (3 stages).
// -----------------------------------------------------------------------------
module cmap_norm #(
	parameter int SAMPLE_BITS = cmap_pkg::SAMPLE_BITS
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic [SAMPLE_BITS-1:0]   sample,
	input  logic [SAMPLE_BITS-1:0]   range_min,
	input  logic [31:0]              span_gain,
	output cmap_pkg::t_beat_t        t_out,
	input  logic                     out_ready
);

	localparam int F   = cmap_pkg::NORM_FRAC_BITS;
	localparam int TW  = cmap_pkg::TW;
	localparam int PW  = SAMPLE_BITS + 32;
	localparam int TTW = SAMPLE_BITS + F;

	logic                   valid_s1, valid_s2, valid_s3;
	logic                   rdy1, rdy2, rdy3;
	logic [SAMPLE_BITS-1:0] d_s1;
	logic [PW-1:0]          prod_s2;
	logic [TW-1:0]          t_s3;
	logic [TTW-1:0]         tt;
	logic [TW-1:0]          t_sat;

	assign rdy3     = !valid_s3 || out_ready;
	assign rdy2     = !valid_s2 || rdy3;
	assign rdy1     = !valid_s1 || rdy2;
	assign in_ready = rdy1;

	assign tt    = prod_s2[PW-1:32-F];
	assign t_sat = (tt > TTW'(cmap_pkg::T_ONE)) ? cmap_pkg::T_ONE : tt[TW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			if (rdy1) valid_s1 <= in_valid;
			if (rdy2) valid_s2 <= valid_s1;
			if (rdy3) valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1) d_s1 <= (sample > range_min) ? sample - range_min : '0;
		if (rdy2) prod_s2 <= d_s1 * span_gain;
		if (rdy3) t_s3 <= t_sat;
	end

	assign t_out.valid = valid_s3;
	assign t_out.t     = t_s3;

endmodule

// File: src/cmap_shade.sv
// -----------------------------------------------------------------------------
// Colormap shader
// Table interpolation, HSV terms and per-map channel fractions (2 stages).
// -----------------------------------------------------------------------------
module cmap_shade (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cmap_pkg::t_beat_t     t_in,
	output logic                  in_ready,
	input  cmap_pkg::cmap_t       map_sel,
	output cmap_pkg::shade_beat_t shade_out,
	input  logic                  out_ready
);

	localparam int F  = cmap_pkg::NORM_FRAC_BITS;
	localparam int TW = cmap_pkg::TW;
	localparam int AW = cmap_pkg::AW;
	localparam int LPW = TW + AW + 2;
	localparam int DIV10_WB = cmap_pkg::DIV10_W;
	localparam logic [F+3:0] NINE_ONE = (F+4)'(9) << F;

	logic                 valid_s4, valid_s5;
	logic                 rdy4, rdy5;

	// stage 4 registers
	logic [TW-1:0]        t_s4;
	logic [AW-1:0]        a_s4 [3];
	cmap_pkg::num_t       lp_s4 [3];
	logic [TW-1:0]        s_s4, sf_s4, sg_s4, v_s4;
	logic [2:0]           sec_s4;
	cmap_pkg::chan_t [2:0] ch_s5;

	// stage 4 logic
	logic                 is_turbo;
	logic [F+2:0]         pos, pos_rem;
	logic [2:0]           idx_raw, idx_max, idx;
	logic [TW-1:0]        frac;
	logic [AW-1:0]        lut_a [3];
	logic signed [AW:0]   diff [3];
	logic signed [LPW-1:0] lp_full [3];
	logic [TW-1:0]        s_hsv, omf, sf, sg, v_hsv;
	logic [F+2:0]         h6;
	logic [2:0]           sec;
	logic [F-1:0]         f;
	logic [2*F:0]         m1;
	logic [2*TW-1:0]      m2;
	logic [F+3:0]         x10;
	logic [F+3+DIV10_WB:0] m3;

	// stage 5 logic
	logic [2*TW-1:0]      mp, mq, mw;
	logic [TW-1:0]        hp, hq, hw;
	cmap_pkg::num_t       nv, np, nq, nw_, tn, u3, u4, u5;
	cmap_pkg::chan_t [2:0] ch;
	cmap_pkg::chan_t      c0, c255;

	assign rdy5     = !valid_s5 || out_ready;
	assign rdy4     = !valid_s4 || rdy5;
	assign in_ready = rdy4;

	// table position and segment
	always_comb begin
		is_turbo = (map_sel == cmap_pkg::MAP_TURBO);
		pos      = is_turbo ? ((F+3)'(t_in.t) << 3) - (F+3)'(t_in.t)
		                    : ((F+3)'(t_in.t) << 2) + (F+3)'(t_in.t);
		idx_raw  = pos[F+2:F];
		idx_max  = is_turbo ? 3'd6 : 3'd4;
		idx      = (idx_raw > idx_max) ? idx_max : idx_raw;
		pos_rem  = pos - ((F+3)'(idx) << F);
		frac     = pos_rem[TW-1:0];
		for (int c = 0; c < 3; c++) begin
			lut_a[c]   = cmap_pkg::lut_entry(map_sel, 2'(c), idx);
			diff[c]    = $signed({1'b0, cmap_pkg::lut_entry(map_sel, 2'(c), idx + 3'd1)})
			           - $signed({1'b0, lut_a[c]});
			lp_full[c] = $signed({1'b0, frac}) * diff[c];
		end
	end

	// hue sector and saturation terms
	always_comb begin
		s_hsv = (map_sel == cmap_pkg::MAP_HSV) ? cmap_pkg::T_ONE : t_in.t;
		h6    = ((F+3)'(t_in.t) << 2) + ((F+3)'(t_in.t) << 1);
		sec   = (h6[F+2:F] > 3'd5) ? 3'd0 : h6[F+2:F];
		f     = h6[F-1:0];
		m1    = s_hsv * f;
		sf    = m1[2*F:F];
		omf   = cmap_pkg::T_ONE - {1'b0, f};
		m2    = s_hsv * omf;
		sg    = m2[2*F:F];
		x10   = NINE_ONE + (F+4)'(t_in.t);
		m3    = x10 * cmap_pkg::DIV10_MUL;
		v_hsv = (map_sel == cmap_pkg::MAP_HSV) ? cmap_pkg::T_ONE
		                                       : m3[cmap_pkg::DIV10_SH+TW-1:cmap_pkg::DIV10_SH];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (rdy4) valid_s4 <= t_in.valid;
			if (rdy5) valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy4) begin
			t_s4   <= t_in.t;
			s_s4   <= s_hsv;
			sf_s4  <= sf;
			sg_s4  <= sg;
			v_s4   <= v_hsv;
			sec_s4 <= sec;
			for (int c = 0; c < 3; c++) begin
				a_s4[c]  <= lut_a[c];
				lp_s4[c] <= cmap_pkg::num_t'(lp_full[c]);
			end
		end
		if (rdy5) ch_s5 <= ch;
	end

	// stage 5: HSV products and per-map channel fractions
	always_comb begin
		mp  = v_s4 * (cmap_pkg::T_ONE - s_s4);
		mq  = v_s4 * (cmap_pkg::T_ONE - sf_s4);
		mw  = v_s4 * (cmap_pkg::T_ONE - sg_s4);
		hp  = mp[2*F:F];
		hq  = mq[2*F:F];
		hw  = mw[2*F:F];
		nv  = cmap_pkg::num_t'(v_s4);
		np  = cmap_pkg::num_t'(hp);
		nq  = cmap_pkg::num_t'(hq);
		nw_ = cmap_pkg::num_t'(hw);
		tn  = cmap_pkg::num_t'(t_s4);
		u3  = tn * cmap_pkg::num_t'(3);
		u4  = tn <<< 2;
		u5  = tn * cmap_pkg::num_t'(5);
		c0   = cmap_pkg::mk('0, cmap_pkg::DEN_1);
		c255 = cmap_pkg::mk(cmap_pkg::N_ONE, cmap_pkg::DEN_1);
		ch[0] = c0;
		ch[1] = c0;
		ch[2] = c0;
		case (map_sel)
			cmap_pkg::MAP_JET: begin
				if (u4 < cmap_pkg::N_ONE) begin
					ch[1] = cmap_pkg::mk(u4, cmap_pkg::DEN_1);
					ch[2] = c255;
				end else if (u4 < (cmap_pkg::N_ONE <<< 1)) begin
					ch[1] = c255;
					ch[2] = cmap_pkg::mk((cmap_pkg::N_ONE <<< 1) - u4, cmap_pkg::DEN_1);
				end else if (u4 < cmap_pkg::N_ONE * cmap_pkg::num_t'(3)) begin
					ch[0] = cmap_pkg::mk(u4 - (cmap_pkg::N_ONE <<< 1), cmap_pkg::DEN_1);
					ch[1] = c255;
				end else begin
					ch[0] = c255;
					ch[1] = cmap_pkg::mk((cmap_pkg::N_ONE <<< 2) - u4, cmap_pkg::DEN_1);
				end
			end
			cmap_pkg::MAP_TURBO, cmap_pkg::MAP_VIRIDIS, cmap_pkg::MAP_INFERNO: begin
				for (int c = 0; c < 3; c++)
					ch[c] = cmap_pkg::mk((cmap_pkg::num_t'(a_s4[c]) <<< F) + lp_s4[c],
					                     cmap_pkg::DEN_1000);
			end
			cmap_pkg::MAP_HOT: begin
				ch[0] = cmap_pkg::mk(u3, cmap_pkg::DEN_1);
				ch[1] = cmap_pkg::mk(u3 - cmap_pkg::N_ONE, cmap_pkg::DEN_1);
				ch[2] = cmap_pkg::mk(u3 - (cmap_pkg::N_ONE <<< 1), cmap_pkg::DEN_1);
			end
			cmap_pkg::MAP_COOL: begin
				ch[0] = cmap_pkg::mk(tn, cmap_pkg::DEN_1);
				ch[1] = cmap_pkg::mk(cmap_pkg::N_ONE - tn, cmap_pkg::DEN_1);
				ch[2] = c255;
			end
			cmap_pkg::MAP_GRAY: begin
				for (int c = 0; c < 3; c++) ch[c] = cmap_pkg::mk(tn, cmap_pkg::DEN_1);
			end
			cmap_pkg::MAP_GRAY_INV: begin
				for (int c = 0; c < 3; c++)
					ch[c] = cmap_pkg::mk(cmap_pkg::N_ONE - tn, cmap_pkg::DEN_1);
			end
			cmap_pkg::MAP_SPRING: begin
				ch[0] = c255;
				ch[1] = cmap_pkg::mk(tn, cmap_pkg::DEN_1);
				ch[2] = cmap_pkg::mk(cmap_pkg::N_ONE - tn, cmap_pkg::DEN_1);
			end
			cmap_pkg::MAP_SUMMER: begin
				ch[0] = cmap_pkg::mk(tn, cmap_pkg::DEN_1);
				ch[1] = cmap_pkg::mk(cmap_pkg::N_ONE + tn, cmap_pkg::DEN_2);
				ch[2] = cmap_pkg::mk(cmap_pkg::N_ONE <<< 1, cmap_pkg::DEN_5);  // 0.4
			end
			cmap_pkg::MAP_AUTUMN: begin
				ch[0] = c255;
				ch[1] = cmap_pkg::mk(tn, cmap_pkg::DEN_1);
			end
			cmap_pkg::MAP_WINTER: begin
				ch[1] = cmap_pkg::mk(tn, cmap_pkg::DEN_1);
				ch[2] = cmap_pkg::mk((cmap_pkg::N_ONE <<< 1) - tn, cmap_pkg::DEN_2);
			end
			cmap_pkg::MAP_COPPER: begin
				ch[0] = cmap_pkg::mk(tn, cmap_pkg::DEN_1);
				ch[1] = cmap_pkg::mk(tn * cmap_pkg::num_t'(25), cmap_pkg::DEN_32);
				ch[2] = cmap_pkg::mk(tn * cmap_pkg::num_t'(199), cmap_pkg::DEN_400);
			end
			cmap_pkg::MAP_PINK: begin
				ch[0] = c255;
				ch[1] = cmap_pkg::mk(cmap_pkg::N_ONE * cmap_pkg::num_t'(3) + tn,
				                     cmap_pkg::DEN_4);
				ch[2] = ch[1];
			end
			cmap_pkg::MAP_OCEAN: begin
				ch[1] = cmap_pkg::mk(tn, cmap_pkg::DEN_1);
				ch[2] = cmap_pkg::mk(cmap_pkg::N_ONE + tn, cmap_pkg::DEN_2);
			end
			cmap_pkg::MAP_TERRAIN: begin
				ch[0] = cmap_pkg::mk(cmap_pkg::N_ONE + tn, cmap_pkg::DEN_2);
				ch[1] = cmap_pkg::mk((cmap_pkg::N_ONE <<< 1) + u3, cmap_pkg::DEN_5);
				ch[2] = cmap_pkg::mk((cmap_pkg::N_ONE - tn) * cmap_pkg::num_t'(3),
				                     cmap_pkg::DEN_10);
			end
			cmap_pkg::MAP_RAINBOW: begin
				if (u5 < cmap_pkg::N_ONE) begin
					ch[0] = c255;
					ch[1] = cmap_pkg::mk(u5, cmap_pkg::DEN_1);
				end else if (u5 < (cmap_pkg::N_ONE <<< 1)) begin
					ch[0] = c255;
					ch[1] = c255;
					ch[2] = cmap_pkg::mk(u5 - cmap_pkg::N_ONE, cmap_pkg::DEN_1);
				end else if (u5 < cmap_pkg::N_ONE * cmap_pkg::num_t'(3)) begin
					ch[0] = cmap_pkg::mk(cmap_pkg::N_ONE * cmap_pkg::num_t'(3) - u5,
					                     cmap_pkg::DEN_1);
					ch[1] = c255;
				end else if (u5 < (cmap_pkg::N_ONE <<< 2)) begin
					ch[1] = cmap_pkg::mk((cmap_pkg::N_ONE <<< 2) - u5, cmap_pkg::DEN_1);
					ch[2] = c255;
				end else begin
					ch[0] = cmap_pkg::mk(u5 - (cmap_pkg::N_ONE <<< 2), cmap_pkg::DEN_10);
					ch[2] = c255;
				end
			end
			cmap_pkg::MAP_HSV, cmap_pkg::MAP_HSV_ALT: begin
				case (sec_s4)
					3'd0: begin
						ch[0] = cmap_pkg::mk(nv, cmap_pkg::DEN_1);
						ch[1] = cmap_pkg::mk(nw_, cmap_pkg::DEN_1);
						ch[2] = cmap_pkg::mk(np, cmap_pkg::DEN_1);
					end
					3'd1: begin
						ch[0] = cmap_pkg::mk(nq, cmap_pkg::DEN_1);
						ch[1] = cmap_pkg::mk(nv, cmap_pkg::DEN_1);
						ch[2] = cmap_pkg::mk(np, cmap_pkg::DEN_1);
					end
					3'd2: begin
						ch[0] = cmap_pkg::mk(np, cmap_pkg::DEN_1);
						ch[1] = cmap_pkg::mk(nv, cmap_pkg::DEN_1);
						ch[2] = cmap_pkg::mk(nw_, cmap_pkg::DEN_1);
					end
					3'd3: begin
						ch[0] = cmap_pkg::mk(np, cmap_pkg::DEN_1);
						ch[1] = cmap_pkg::mk(nq, cmap_pkg::DEN_1);
						ch[2] = cmap_pkg::mk(nv, cmap_pkg::DEN_1);
					end
					3'd4: begin
						ch[0] = cmap_pkg::mk(nw_, cmap_pkg::DEN_1);
						ch[1] = cmap_pkg::mk(np, cmap_pkg::DEN_1);
						ch[2] = cmap_pkg::mk(nv, cmap_pkg::DEN_1);
					end
					default: begin
						ch[0] = cmap_pkg::mk(nv, cmap_pkg::DEN_1);
						ch[1] = cmap_pkg::mk(np, cmap_pkg::DEN_1);
						ch[2] = cmap_pkg::mk(nq, cmap_pkg::DEN_1);
					end
				endcase
			end
			default: begin
				ch[0] = c0;
				ch[1] = c0;
				ch[2] = c0;
			end
		endcase
	end

	assign shade_out.valid = valid_s5;
	assign shade_out.ch    = ch_s5;

endmodule

// File: src/cmap_scale.sv
// -----------------------------------------------------------------------------
// Colormap channel scaler
// Clamp each fraction to [0,1] and form floor(255*num/den) (2 stages).
// -----------------------------------------------------------------------------
module cmap_scale (
	input  logic                  clk,
	input  logic                  arst_n,
	input  cmap_pkg::shade_beat_t shade_in,
	output logic                  in_ready,
	output logic                  out_valid,
	input  logic                  out_ready,
	output logic [7:0]            red,
	output logic [7:0]            green,
	output logic [7:0]            blue
);

	localparam int F  = cmap_pkg::NORM_FRAC_BITS;
	localparam int NW = cmap_pkg::NW;
	localparam int XW = NW + 8;
	localparam int YW = cmap_pkg::YW;
	localparam int RW = cmap_pkg::RW;

	logic                  valid_s6, valid_s7;
	logic                  rdy6, rdy7;
	logic [YW-1:0]         y_s6 [3];
	logic [1:0]            kc_s6 [3];
	logic [7:0]            pix_s7 [3];

	cmap_pkg::num_t        dmax [3];
	cmap_pkg::num_t        nc [3];
	logic [XW-1:0]         x [3];
	logic [XW-1:0]         xs [3];
	logic [XW-1:0]         xss [3];
	logic [YW+RW-1:0]      q [3];

	assign rdy7     = !valid_s7 || out_ready;
	assign rdy6     = !valid_s6 || rdy7;
	assign in_ready = rdy6;

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			dmax[c] = cmap_pkg::den_full(shade_in.ch[c].den);
			if (shade_in.ch[c].num < 0)
				nc[c] = '0;
			else if (shade_in.ch[c].num > dmax[c])
				nc[c] = dmax[c];
			else
				nc[c] = shade_in.ch[c].num;
			// 255*n = 256*n - n, n nonnegative here
			x[c]   = (XW'(nc[c]) << 8) - XW'(nc[c]);
			xs[c]  = x[c] >> F;
			xss[c] = xs[c] >> cmap_pkg::den_shift(shade_in.ch[c].den);
		end
	end

	always_comb begin
		for (int c = 0; c < 3; c++)
			q[c] = y_s6[c] * cmap_pkg::k_recip(kc_s6[c]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s6 <= 1'b0;
			valid_s7 <= 1'b0;
		end else begin
			if (rdy6) valid_s6 <= shade_in.valid;
			if (rdy7) valid_s7 <= valid_s6;
		end
	end

	always_ff @(posedge clk) begin
		for (int c = 0; c < 3; c++) begin
			if (rdy6) begin
				y_s6[c]  <= xss[c][YW-1:0];
				kc_s6[c] <= cmap_pkg::den_kc(shade_in.ch[c].den);
			end
			if (rdy7) pix_s7[c] <= q[c][cmap_pkg::RSH+7:cmap_pkg::RSH];
		end
	end

	assign out_valid = valid_s7;
	assign red       = pix_s7[0];
	assign green     = pix_s7[1];
	assign blue      = pix_s7[2];

endmodule

// File: src/scalar_to_rgb_colormap_top.sv
// -----------------------------------------------------------------------------
// Scalar to RGB colormap
// Normalizes a scalar sample and maps it to a pixel through one of 19 maps.
// -----------------------------------------------------------------------------
// channel   signals                               beat
// sample    sample_valid / sample_stall, sample   one scalar in
// pixel     pixel_valid / pixel_stall, r/g/b      one 8-bit RGB pixel out
// config    APB psel/penable/pwrite/paddr/pwdata  one register write
//
// One beat per cycle sustained while pixel_stall is low, through the 7-stage pipe
// (normalize 3, shade 2, scale 2). Each stage holds while its successor is full
// and stalled, so bubbles close up. arst_n clears all stage valids and the
// registers to map 0, range_min 0, span_gain 65536.
// -----------------------------------------------------------------------------
module scalar_to_rgb_colormap_top #(
	parameter int SAMPLE_BITS = cmap_pkg::SAMPLE_BITS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        sample_valid,
	output logic                        sample_stall,
	input  logic [SAMPLE_BITS-1:0]      sample,
	output logic                        pixel_valid,
	input  logic                        pixel_stall,
	output logic [7:0]                  red,
	output logic [7:0]                  green,
	output logic [7:0]                  blue,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [cmap_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);

	logic [4:0]              map_sel_q;
	logic [SAMPLE_BITS-1:0]  range_min_q;
	logic [31:0]             span_gain_q;
	logic                    wr_en;
	cmap_pkg::reg_t          reg_idx;

	logic                    norm_ready, shade_ready;
	cmap_pkg::t_beat_t       t_beat;
	cmap_pkg::shade_beat_t   shade_beat;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = cmap_pkg::reg_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_sel_q   <= 5'd0;
			range_min_q <= '0;
			span_gain_q <= 32'd65536;
		end else if (wr_en) begin
			unique case (reg_idx)
				cmap_pkg::REG_MAP_SEL:   map_sel_q   <= pwdata[4:0];
				cmap_pkg::REG_RANGE_MIN: range_min_q <= pwdata[SAMPLE_BITS-1:0];
				cmap_pkg::REG_SPAN_GAIN: span_gain_q <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			cmap_pkg::REG_MAP_SEL:   prdata = 32'(map_sel_q);
			cmap_pkg::REG_RANGE_MIN: prdata = 32'(range_min_q);
			cmap_pkg::REG_SPAN_GAIN: prdata = span_gain_q;
			default:                 prdata = '0;
		endcase
	end

	cmap_norm #(
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_norm (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (sample_valid),
		.in_ready  (norm_ready),
		.sample    (sample),
		.range_min (range_min_q),
		.span_gain (span_gain_q),
		.t_out     (t_beat),
		.out_ready (shade_ready)
	);

	logic scale_ready;

	cmap_shade u_shade (
		.clk       (clk),
		.arst_n    (arst_n),
		.t_in      (t_beat),
		.in_ready  (shade_ready),
		.map_sel   (cmap_pkg::cmap_t'(map_sel_q)),
		.shade_out (shade_beat),
		.out_ready (scale_ready)
	);

	cmap_scale u_scale (
		.clk       (clk),
		.arst_n    (arst_n),
		.shade_in  (shade_beat),
		.in_ready  (scale_ready),
		.out_valid (pixel_valid),
		.out_ready (!pixel_stall),
		.red       (red),
		.green     (green),
		.blue      (blue)
	);

	assign sample_stall = !norm_ready;

endmodule

// File: src/cmap_checker.sv
// -----------------------------------------------------------------------------
// Colormap port checker
// Tracks beats in flight from the ports and checks pipe occupancy rules.
// -----------------------------------------------------------------------------
`include "scalar_to_rgb_colormap_top_macros.svh"

module cmap_checker (
	input logic clk,
	input logic arst_n,
	input logic sample_valid,
	input logic sample_stall,
	input logic pixel_valid,
	input logic pixel_stall
);

	localparam logic [3:0] DEPTH = 4'd7;

	logic [3:0] cnt_q;
	logic       in_acc, out_acc;

	assign in_acc  = sample_valid && !sample_stall;
	assign out_acc = pixel_valid && !pixel_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cnt_q <= 4'd0;
		else if (in_acc && !out_acc)
			cnt_q <= cnt_q + 4'd1;
		else if (out_acc && !in_acc)
			cnt_q <= cnt_q - 4'd1;
	end

	`CMAP_ASSERT_NEXT(a_pixel_hold, clk, arst_n, pixel_valid && pixel_stall, pixel_valid, "pixel beat dropped while stalled")
	`CMAP_ASSERT(a_no_phantom, clk, arst_n, !pixel_valid || cnt_q != 4'd0, "pixel beat with no sample in flight")
	`CMAP_ASSERT(a_stall_full, clk, arst_n, !sample_stall || cnt_q == DEPTH, "sample stalled with pipe not full")
	`CMAP_ASSERT(a_depth, clk, arst_n, cnt_q <= DEPTH, "more beats in flight than pipe stages")

endmodule

bind scalar_to_rgb_colormap_top cmap_checker u_cmap_checker (.*);

// File: sim/scalar_to_rgb_colormap_top_test.sv
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// Colormap pipe testbench
// Programs the map, offset and gain over APB, streams samples in bursts against
// a stalling pixel sink and checks every pixel against a local shading model.
// -----------------------------------------------------------------------------
module scalar_to_rgb_colormap_top_test;

	localparam longint ONE = 64'd1 << 16;
	localparam logic [3:0] ADDR_UNUSED = 4'd12;
	localparam int HOLD_AT = 200;
	localparam int HOLD_CYCLES = 300;

	localparam longint TURBO_K [3][8] = '{
		'{190, 70, 0, 490, 1000, 1000, 840, 500},
		'{0, 150, 650, 950, 1000, 440, 0, 0},
		'{500, 840, 1000, 1000, 950, 650, 150, 0}};
	localparam longint VIRIDIS_K [3][6] = '{
		'{267, 282, 253, 163, 128, 267},
		'{4, 141, 365, 659, 808, 992},
		'{329, 458, 659, 788, 878, 984}};
	localparam longint INFERNO_K [3][6] = '{
		'{1, 302, 601, 903, 1000, 988},
		'{0, 137, 287, 428, 729, 998},
		'{13, 295, 573, 758, 964, 998}};

	typedef struct packed {
		logic [7:0] r;
		logic [7:0] g;
		logic [7:0] b;
	} pix_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic sample_valid = 1'b0;
	logic sample_stall;
	logic [15:0] sample = '0;
	logic pixel_valid;
	logic pixel_stall = 1'b0;
	logic [7:0] red, green, blue;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [3:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;

	logic [4:0] cfg_map = 5'd0;
	logic [15:0] cfg_min = 16'd0;
	logic [31:0] cfg_gain = 32'd65536;

	logic [15:0] pending_samples[$];
	pix_t expected_pixels[$];
	int n_accepted = 0;
	int n_errors = 0;
	int burst_left = 0, gap_left = 0;
	int hold_left = 0;
	bit hold_done = 1'b0;
	int stall_mode = 0, stall_tick = 0;

	scalar_to_rgb_colormap_top u_top (
		.clk, .arst_n, .sample_valid, .sample_stall, .sample,
		.pixel_valid, .pixel_stall, .red, .green, .blue,
		.psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
	);

	always #6 clk = ~clk;

	function automatic longint chan(longint num, longint den);
		if (num < 0) num = 0;
		if (num > den) num = den;
		return (255 * num) / den;
	endfunction

	function automatic longint tab(cmap_pkg::cmap_t m, int k, longint i);
		case (m)
			cmap_pkg::MAP_TURBO:   return TURBO_K[k][i];
			cmap_pkg::MAP_VIRIDIS: return VIRIDIS_K[k][i];
			default:               return INFERNO_K[k][i];
		endcase
	endfunction

	function automatic pix_t interp(cmap_pkg::cmap_t m, int n, longint t);
		longint pos, idx, a, b, c[3];
		pos = t * (n - 1);
		idx = pos >>> 16;
		if (idx > n - 2) idx = n - 2;
		pos = pos - idx * ONE;
		for (int k = 0; k < 3; k++) begin
			a = tab(m, k, idx);
			b = tab(m, k, idx + 1);
			c[k] = chan(a * ONE + pos * (b - a), 1000 * ONE);
		end
		return '{c[0][7:0], c[1][7:0], c[2][7:0]};
	endfunction

	function automatic pix_t hsv_px(longint t, longint s, longint v);
		longint h6, i, f, p, q, w, r, g, b;
		h6 = 6 * t;
		i = h6 >>> 16;
		f = h6 - i * ONE;
		p = (v * (ONE - s)) >>> 16;
		q = (v * (ONE - ((s * f) >>> 16))) >>> 16;
		w = (v * (ONE - ((s * (ONE - f)) >>> 16))) >>> 16;
		if (i >= 6) i = 0;
		case (i)
			0: begin r = v; g = w; b = p; end
			1: begin r = q; g = v; b = p; end
			2: begin r = p; g = v; b = w; end
			3: begin r = p; g = q; b = v; end
			4: begin r = w; g = p; b = v; end
			default: begin r = v; g = p; b = q; end
		endcase
		r = chan(r, ONE); g = chan(g, ONE); b = chan(b, ONE);
		return '{r[7:0], g[7:0], b[7:0]};
	endfunction

	function automatic pix_t shade(logic [15:0] s);
		longint unsigned prod, tt;
		longint t, u, r, g, b;
		t = 0;
		r = 0; g = 0; b = 0;
		if (s > cfg_min) begin
			prod = longint'(s - cfg_min) * longint'(cfg_gain);
			tt = prod >> 16;
			t = (tt > ONE) ? ONE : longint'(tt);
		end
		case (cfg_map)
			cmap_pkg::MAP_JET: begin
				u = 4 * t;
				if (u < ONE) begin r = 0; g = chan(u, ONE); b = 255; end
				else if (u < 2 * ONE) begin r = 0; g = 255; b = chan(2 * ONE - u, ONE); end
				else if (u < 3 * ONE) begin r = chan(u - 2 * ONE, ONE); g = 255; b = 0; end
				else begin r = 255; g = chan(4 * ONE - u, ONE); b = 0; end
			end
			cmap_pkg::MAP_TURBO:   return interp(cmap_pkg::MAP_TURBO, 8, t);
			cmap_pkg::MAP_VIRIDIS: return interp(cmap_pkg::MAP_VIRIDIS, 6, t);
			cmap_pkg::MAP_INFERNO: return interp(cmap_pkg::MAP_INFERNO, 6, t);
			cmap_pkg::MAP_HOT: begin
				u = 3 * t;
				r = chan(u, ONE); g = chan(u - ONE, ONE); b = chan(u - 2 * ONE, ONE);
			end
			cmap_pkg::MAP_COOL: begin
				r = chan(t, ONE); g = chan(ONE - t, ONE); b = 255;
			end
			cmap_pkg::MAP_GRAY:     begin r = chan(t, ONE); g = r; b = r; end
			cmap_pkg::MAP_GRAY_INV: begin r = chan(ONE - t, ONE); g = r; b = r; end
			cmap_pkg::MAP_SPRING: begin
				r = 255; g = chan(t, ONE); b = chan(ONE - t, ONE);
			end
			cmap_pkg::MAP_SUMMER: begin
				r = chan(t, ONE); g = chan(ONE + t, 2 * ONE); b = 102;
			end
			cmap_pkg::MAP_AUTUMN: begin r = 255; g = chan(t, ONE); b = 0; end
			cmap_pkg::MAP_WINTER: begin
				r = 0; g = chan(t, ONE); b = chan(2 * ONE - t, 2 * ONE);
			end
			cmap_pkg::MAP_COPPER: begin
				r = chan(t, ONE); g = chan(25 * t, 32 * ONE); b = chan(199 * t, 400 * ONE);
			end
			cmap_pkg::MAP_PINK: begin r = 255; g = chan(3 * ONE + t, 4 * ONE); b = g; end
			cmap_pkg::MAP_OCEAN: begin
				r = 0; g = chan(t, ONE); b = chan(ONE + t, 2 * ONE);
			end
			cmap_pkg::MAP_TERRAIN: begin
				r = chan(ONE + t, 2 * ONE);
				g = chan(2 * ONE + 3 * t, 5 * ONE);
				b = chan(3 * (ONE - t), 10 * ONE);
			end
			cmap_pkg::MAP_RAINBOW: begin
				u = 5 * t;
				if (u < ONE) begin r = 255; g = chan(u, ONE); b = 0; end
				else if (u < 2 * ONE) begin r = 255; g = 255; b = chan(u - ONE, ONE); end
				else if (u < 3 * ONE) begin r = chan(3 * ONE - u, ONE); g = 255; b = 0; end
				else if (u < 4 * ONE) begin r = 0; g = chan(4 * ONE - u, ONE); b = 255; end
				else begin r = chan(u - 4 * ONE, 10 * ONE); g = 0; b = 255; end
			end
			cmap_pkg::MAP_HSV:     return hsv_px(t, ONE, ONE);
			cmap_pkg::MAP_HSV_ALT: return hsv_px(t, t, (9 * ONE + t) / 10);
			default: ; // unused map numbers give black
		endcase
		return '{r[7:0], g[7:0], b[7:0]};
	endfunction

	task automatic report(string what, pix_t got, pix_t want);
		$display("mismatch %s at %0t: got %0d/%0d/%0d want %0d/%0d/%0d", what, $realtime,
			got.r, got.g, got.b, want.r, want.g, want.b);
		n_errors++;
	endtask

	// sample driver: bursts and gaps, payload held while stalled
	always @(posedge clk) begin
		if (arst_n) begin
			if (sample_valid && !sample_stall) begin
				expected_pixels.push_back(shade(sample));
				n_accepted++;
			end
			if (!(sample_valid && sample_stall)) begin
				if (gap_left > 0) begin
					gap_left--;
					sample_valid <= 1'b0;
				end else if (pending_samples.size() > 0) begin
					sample <= pending_samples.pop_front();
					sample_valid <= 1'b1;
					if (burst_left > 0) burst_left--;
					else begin
						burst_left = $urandom_range(0, 3) == 0 ? 60 : $urandom_range(1, 16);
						gap_left = $urandom_range(0, 5);
					end
				end else begin
					sample_valid <= 1'b0;
				end
			end
		end
	end

	// pixel sink stall pattern, plus one long hold-off to back up the pipe
	always @(posedge clk) begin
		if (arst_n) begin
			stall_tick++;
			if (stall_tick % 50 == 0) stall_mode = $urandom_range(0, 3);
			if (!hold_done && n_accepted >= HOLD_AT) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				pixel_stall <= 1'b1;
			end else begin
				case (stall_mode)
					0: pixel_stall <= 1'b0;
					1: pixel_stall <= $urandom_range(0, 1);
					2: pixel_stall <= (stall_tick % 3 == 0);
					default: pixel_stall <= $urandom_range(0, 4) != 0;
				endcase
			end
		end
	end

	// pixel monitor
	always @(posedge clk) begin
		pix_t got;
		if (arst_n && pixel_valid && !pixel_stall) begin
			got = '{red, green, blue};
			if (expected_pixels.size() == 0) report("unexpected pixel", got, '0);
			else if (got !== expected_pixels[0]) begin
				report("pixel", got, expected_pixels[0]);
				void'(expected_pixels.pop_front());
			end else void'(expected_pixels.pop_front());
		end
	end

	task automatic reg_write(logic [3:0] addr, logic [31:0] data);
		@(posedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1; paddr <= addr; pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		case (addr)
			{cmap_pkg::REG_MAP_SEL, 2'b00}:   cfg_map = data[4:0];
			{cmap_pkg::REG_RANGE_MIN, 2'b00}: cfg_min = data[15:0];
			{cmap_pkg::REG_SPAN_GAIN, 2'b00}: cfg_gain = data;
			default: ;
		endcase
	endtask

	task automatic drain;
		while (pending_samples.size() > 0 || expected_pixels.size() > 0 || sample_valid)
			@(posedge clk);
		repeat (12) @(posedge clk);
	endtask

	task automatic setup(logic [4:0] m, logic [15:0] rmin, logic [31:0] gain);
		drain();
		reg_write({cmap_pkg::REG_MAP_SEL, 2'b00}, {27'd0, m});
		reg_write({cmap_pkg::REG_RANGE_MIN, 2'b00}, {16'd0, rmin});
		reg_write({cmap_pkg::REG_SPAN_GAIN, 2'b00}, gain);
	endtask

	initial begin
		logic [4:0] m;
		logic [15:0] rmin;
		logic [31:0] gain;
		int span;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// reset values: Jet, t equals sample
		pending_samples = '{16'd0, 16'd16384, 16'd32768, 16'd49152, 16'hffff};
		// t saturates at one on a table map; below and at offset give zero
		setup(cmap_pkg::MAP_TURBO, 16'd100, 32'hffffffff);
		pending_samples = '{16'd99, 16'd100, 16'd101, 16'hffff};
		setup(cmap_pkg::MAP_HSV_ALT, 16'd100, 32'hffffffff);
		pending_samples = '{16'd101, 16'd102, 16'hffff};
		// zero gain
		setup(cmap_pkg::MAP_HOT, 16'd0, 32'd0);
		pending_samples = '{16'hffff, 16'd1234};
		// unused map numbers
		setup(5'd19, 16'd0, 32'd65536);
		pending_samples = '{16'hffff, 16'h8000};
		setup(5'd31, 16'hffff, 32'd65536);
		pending_samples = '{16'hffff, 16'd0};
		drain();
		reg_write(ADDR_UNUSED, 32'hffffffff);
		setup(cmap_pkg::MAP_HOT, 16'd0, 32'd65536);
		pending_samples = '{16'd21845, 16'd43690, 16'd43691};

		for (int ph = 0; ph < 32; ph++) begin
			m = $urandom_range(0, 9) == 0 ? $urandom_range(19, 31) : $urandom_range(0, 18);
			case ($urandom_range(0, 3))
				0: rmin = 16'd0;
				1: rmin = 16'hffff;
				default: rmin = $urandom;
			endcase
			case ($urandom_range(0, 5))
				0: gain = 32'd0;
				1: gain = 32'hffffffff;
				2: gain = 32'd65536;
				default: begin
					span = $urandom_range(1, 65535);
					gain = 32'((64'd1 << 32) / span);
				end
			endcase
			setup(m, rmin, gain);
			for (int k = 0; k < 19; k++)
				pending_samples.push_back($urandom_range(0, 2) == 0 ?
					16'(rmin + $urandom_range(0, 300)) : 16'($urandom));
		end
		drain();
		repeat (20) @(posedge clk);
		if (n_errors == 0 && expected_pixels.size() == 0) $display("PASS");
		else $display("FAIL");
		$finish;
	end

	initial begin
		#3000000;
		$display("FAIL");
		$finish;
	end
endmodule
